// File: rtl/csob_pkg.sv
// Shared constants, widths and the blend helper for the clipped source-over blit unit.
`default_nettype none

package csob_pkg;

    // Largest destination dimension; larger register values saturate to this.
    localparam int unsigned MAX_DEST_DIM    = 8192;
    // Overlay coordinates at or above this are clipped.
    localparam int unsigned MAX_OVERLAY_DIM = 512;

    localparam int unsigned DIM_W       = 14;
    localparam int unsigned COORD_W     = 9;
    localparam int unsigned POS_W       = 13;
    localparam int unsigned PIX_W       = 32;
    localparam int unsigned ADDR_W      = 26;
    localparam int unsigned CH_W        = 8;
    localparam int unsigned NUM_CH      = 4;
    localparam int unsigned PROD_W      = 2 * CH_W;
    localparam int unsigned CFG_INDEX_W = 8;

    localparam int unsigned IN_FIELDS_W  = 2 * COORD_W + 2 * PIX_W;
    localparam int unsigned S_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned OUT_FIELDS_W = 1 + ADDR_W + PIX_W;
    localparam int unsigned M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CFG_INDEX_W-1:0] REG_DEST_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_HEIGHT = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y    = 8'd3;

    localparam logic [DIM_W-1:0] DEST_WIDTH_RST  = 14'd1920;
    localparam logic [DIM_W-1:0] DEST_HEIGHT_RST = 14'd1080;

    localparam logic [CH_W-1:0] CH_MAX   = 8'hff;
    localparam logic [PROD_W:0] ROUND_UP = 17'd127;

    // Rounded divide by 255 of a channel product, then source add with saturation.
    // For y below 65535, floor(y / 255) equals (y + (y >> 8) + 1) >> 8.
    function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] fg,
                                                    input logic [PROD_W-1:0] prod);
        logic [PROD_W:0] y;
        logic [PROD_W:0] q;
        logic [CH_W:0]   sum;
        y   = {1'b0, prod} + ROUND_UP;
        q   = (y + (y >> 8) + 17'd1) >> 8;
        sum = {1'b0, fg} + {1'b0, q[CH_W-1:0]};
        return sum[CH_W] ? CH_MAX : sum[CH_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/clipped_source_over_blit_unit.sv
// Top level of the clipped source-over blit unit: placement, clipping, addressing and blend.
`default_nettype none

// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   src_col, src_row, src_pixel, dst_pixel
// m_axis    out        m_axis_tvalid/m_axis_tready   write_enable, target_address, blended_pixel
// cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data (14-bit register value)
//
// One item enters per clock while the pipeline is not stalled; each item passes three register
// stages: coordinate offset, clip test and the channel products; then the row times width
// product and the divide-by-255 rounding; then the final address add into the output
// register.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the register defaults
// (width 1920, height 1080, both offsets 0).
// A stage holds its item while the stage after it is full and stalled, and empty stages
// keep filling, so a stalled output still lets up to two more items enter.

module clipped_source_over_blit_unit
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [8:0] src_col, [17:9] src_row, [49:18] src_pixel, [81:50] dst_pixel, rest zero
    input  wire logic [csob_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] write_enable, [26:1] target_address, [58:27] blended_pixel, rest zero
    output logic [csob_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [csob_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [csob_pkg::DIM_W-1:0]        cfg_data
);
    import csob_pkg::*;

    // Configuration registers.
    logic [DIM_W-1:0] dest_width_reg;
    logic [DIM_W-1:0] dest_height_reg;
    logic [DIM_W-1:0] offset_x_reg;
    logic [DIM_W-1:0] offset_y_reg;

    // Input field unpacking.
    logic [COORD_W-1:0] in_col;
    logic [COORD_W-1:0] in_row;
    logic [PIX_W-1:0]   in_src;
    logic [PIX_W-1:0]   in_dst;

    // Stage 1 results.
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_inside_reg;
    logic                  s1_inside_next;
    logic [POS_W-1:0]      s1_tx_reg;
    logic [POS_W-1:0]      s1_tx_next;
    logic [POS_W-1:0]      s1_ty_reg;
    logic [POS_W-1:0]      s1_ty_next;
    logic [DIM_W-1:0]      s1_w_reg;
    logic [DIM_W-1:0]      s1_w_next;
    logic [PIX_W-1:0]      s1_src_reg;
    logic [PROD_W-1:0]     s1_prod_reg  [NUM_CH];
    logic [PROD_W-1:0]     s1_prod_next [NUM_CH];

    // Stage 2 results.
    logic                  s2_valid_reg;
    logic                  s2_valid_next;
    logic                  s2_inside_reg;
    logic [POS_W-1:0]      s2_tx_reg;
    logic [ADDR_W:0]       s2_rowbase_reg;
    logic [ADDR_W:0]       s2_rowbase_next;
    logic [PIX_W-1:0]      s2_blend_reg;
    logic [PIX_W-1:0]      s2_blend_next;

    // Output register.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_we_reg;
    logic [ADDR_W-1:0]     out_addr_reg;
    logic [ADDR_W-1:0]     out_addr_next;
    logic [PIX_W-1:0]      out_pix_reg;
    logic [PIX_W-1:0]      out_pix_next;

    // Stage advance controls; each stage takes an item when empty or when it drains.
    logic out_take;
    logic s2_take;
    logic s1_take;

    // Stage 1 working values.
    logic signed [DIM_W:0] tx_full;
    logic signed [DIM_W:0] ty_full;
    logic [DIM_W-1:0]      w_sat;
    logic [DIM_W-1:0]      h_sat;
    logic [CH_W-1:0]       inv_alpha;
    logic                  overlay_ok;
    logic [ADDR_W:0]       addr_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_width_reg  <= DEST_WIDTH_RST;
            dest_height_reg <= DEST_HEIGHT_RST;
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEST_WIDTH:  dest_width_reg  <= cfg_data;
                REG_DEST_HEIGHT: dest_height_reg <= cfg_data;
                REG_OFFSET_X:    offset_x_reg    <= cfg_data;
                REG_OFFSET_Y:    offset_y_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign in_col = s_axis_tdata[COORD_W-1:0];
    assign in_row = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign in_src = s_axis_tdata[2*COORD_W+PIX_W-1:2*COORD_W];
    assign in_dst = s_axis_tdata[2*COORD_W+2*PIX_W-1:2*COORD_W+PIX_W];

    assign out_take      = !out_valid_reg || m_axis_tready;
    assign s2_take       = !s2_valid_reg || out_take;
    assign s1_take       = !s1_valid_reg || s2_take;
    assign s_axis_tready = s1_take;

    // Stage 1: place the pixel, clip it, and form the four channel products.
    always_comb
    begin
        tx_full = $signed({offset_x_reg[DIM_W-1], offset_x_reg})
                + $signed({{(DIM_W+1-COORD_W){1'b0}}, in_col});
        ty_full = $signed({offset_y_reg[DIM_W-1], offset_y_reg})
                + $signed({{(DIM_W+1-COORD_W){1'b0}}, in_row});
        w_sat = (dest_width_reg > DIM_W'(MAX_DEST_DIM)) ? DIM_W'(MAX_DEST_DIM) : dest_width_reg;
        h_sat = (dest_height_reg > DIM_W'(MAX_DEST_DIM)) ? DIM_W'(MAX_DEST_DIM) : dest_height_reg;
        overlay_ok = ({1'b0, in_col} < (COORD_W+1)'(MAX_OVERLAY_DIM))
                  && ({1'b0, in_row} < (COORD_W+1)'(MAX_OVERLAY_DIM));
        s1_inside_next = overlay_ok
                      && !tx_full[DIM_W] && (tx_full[DIM_W-1:0] < w_sat)
                      && !ty_full[DIM_W] && (ty_full[DIM_W-1:0] < h_sat);
        s1_tx_next = tx_full[POS_W-1:0];
        s1_ty_next = ty_full[POS_W-1:0];
        s1_w_next  = w_sat;
        inv_alpha  = CH_MAX - in_src[PIX_W-1 -: CH_W];
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            s1_prod_next[ch] = {{CH_W{1'b0}}, in_dst[ch*CH_W +: CH_W]}
                             * {{CH_W{1'b0}}, inv_alpha};
        end
    end

    // Stage 2: row base address and rounded, saturated channel blend.
    always_comb
    begin
        s2_rowbase_next = (ADDR_W+1)'(s1_ty_reg) * (ADDR_W+1)'(s1_w_reg);
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            s2_blend_next[ch*CH_W +: CH_W] = mix_channel(s1_src_reg[ch*CH_W +: CH_W],
                                                         s1_prod_reg[ch]);
        end
    end

    // Stage 3: final address; a clipped pixel reports zero address and zero pixel.
    always_comb
    begin
        addr_full     = s2_rowbase_reg + (ADDR_W+1)'(s2_tx_reg);
        out_addr_next = s2_inside_reg ? addr_full[ADDR_W-1:0] : '0;
        out_pix_next  = s2_inside_reg ? s2_blend_reg : '0;
    end

    always_comb
    begin
        s1_valid_next  = s1_take  ? s_axis_tvalid : s1_valid_reg;
        s2_valid_next  = s2_take  ? s1_valid_reg  : s2_valid_reg;
        out_valid_next = out_take ? s2_valid_reg  : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take && s_axis_tvalid)
        begin
            s1_inside_reg <= s1_inside_next;
            s1_tx_reg     <= s1_tx_next;
            s1_ty_reg     <= s1_ty_next;
            s1_w_reg      <= s1_w_next;
            s1_src_reg    <= in_src;
            s1_prod_reg   <= s1_prod_next;
        end
        if (s2_take && s1_valid_reg)
        begin
            s2_inside_reg  <= s1_inside_reg;
            s2_tx_reg      <= s1_tx_reg;
            s2_rowbase_reg <= s2_rowbase_next;
            s2_blend_reg   <= s2_blend_next;
        end
        if (out_take && s2_valid_reg)
        begin
            out_we_reg   <= s2_inside_reg;
            out_addr_reg <= out_addr_next;
            out_pix_reg  <= out_pix_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-OUT_FIELDS_W){1'b0}}, out_pix_reg, out_addr_reg,
                            out_we_reg};

endmodule

`default_nettype wire

// File: rtl/csob_checker.sv
// Port-level checker for the clipped source-over blit unit and its bind statement.
`default_nettype none

module csob_checker
(
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic [csob_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [csob_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready,
    input wire logic [csob_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input wire logic [csob_pkg::DIM_W-1:0]        cfg_data
);
    import csob_pkg::*;

    logic out_we;
    logic in_used;

    assign out_we  = m_axis_tdata[0];
    assign in_used = s_axis_tvalid | (|s_axis_tdata) | cfg_valid | cfg_ready
                   | (|cfg_index) | (|cfg_data);

    // A result waiting on a stalled output stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A clipped pixel carries a zero address and a zero pixel.
    a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !out_we |-> m_axis_tdata[M_TDATA_W-1:1] == '0)
        else $error("clipped result carries nonzero payload");

    // The input only backs up when a result sits stalled at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_used || !in_used |-> cfg_ready)
        else $error("configuration port not ready");

endmodule

bind clipped_source_over_blit_unit csob_checker u_csob_checker (.*);

`default_nettype wire

// File: tb/sv/clipped_source_over_blit_unit_test.sv
// Self-checking testbench for the clipped source-over blit unit.
module clipped_source_over_blit_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import csob_pkg::*;

    // The run is cut off here if the stream stalls for good.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Extra wait, as margin over a pipeline of three stages, once every result is back.
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned RANDOM_PHASES = 15;
    localparam int unsigned PHASE_ITEMS = 110;

    // One result item as the block should produce it.
    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] target_address;
        logic [PIX_W-1:0]  blended_pixel;
    } blit_result_t;

    // Keeps its own copy of the placement and size registers, predicts the result of
    // each accepted pixel and compares the results in order of arrival.
    class blit_scoreboard;
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        logic [DIM_W-1:0] offset_x_reg;
        logic [DIM_W-1:0] offset_y_reg;
        blit_result_t     pending_writes[$];
        int unsigned      errors;

        function new();
            width_reg    = DEST_WIDTH_RST;
            height_reg   = DEST_HEIGHT_RST;
            offset_x_reg = '0;
            offset_y_reg = '0;
            errors       = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [DIM_W-1:0] value);
            case (index)
                REG_DEST_WIDTH:  width_reg    = value;
                REG_DEST_HEIGHT: height_reg   = value;
                REG_OFFSET_X:    offset_x_reg = value;
                REG_OFFSET_Y:    offset_y_reg = value;
                default: ;
            endcase
        endfunction

        // Source plus the rounded, alpha-weighted destination, saturated at full scale.
        function int over_channel(int fg, int bg, int inv);
            int sum;
            sum = fg + (bg * inv + 127) / 255;
            return (sum > 255) ? 255 : sum;
        endfunction

        function blit_result_t place_and_blend(logic [COORD_W-1:0] col,
                                               logic [COORD_W-1:0] row,
                                               logic [PIX_W-1:0] src,
                                               logic [PIX_W-1:0] dst);
            blit_result_t res;
            int           eff_w;
            int           eff_h;
            int           ox;
            int           oy;
            int           tx;
            int           ty;
            int           inv;
            longint       addr;
            eff_w = (width_reg > MAX_DEST_DIM) ? MAX_DEST_DIM : int'(width_reg);
            eff_h = (height_reg > MAX_DEST_DIM) ? MAX_DEST_DIM : int'(height_reg);
            ox    = $signed(offset_x_reg);
            oy    = $signed(offset_y_reg);
            tx    = ox + int'(col);
            ty    = oy + int'(row);
            res   = '0;
            if (tx >= 0 && ty >= 0 && tx < eff_w && ty < eff_h) begin
                addr = longint'(ty) * eff_w + tx;
                inv  = 255 - int'(src[31:24]);
                res.write_enable   = 1'b1;
                res.target_address = addr[ADDR_W-1:0];
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    res.blended_pixel[ch*CH_W +: CH_W] =
                        8'(over_channel(src[ch*CH_W +: CH_W], dst[ch*CH_W +: CH_W], inv));
                end
            end
            return res;
        endfunction

        function void note_pixel(logic [S_TDATA_W-1:0] tdata);
            pending_writes = {pending_writes,
                              place_and_blend(tdata[8:0], tdata[17:9],
                                              tdata[49:18], tdata[81:50])};
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata);
            blit_result_t want;
            blit_result_t got;
            got = '{tdata[0], tdata[26:1], tdata[58:27]};
            if (pending_writes.size() == 0) begin
                $display("%0t: result %0h arrived with nothing outstanding", $time, got);
                errors++;
                return;
            end
            want = pending_writes.pop_front();
            if (got.write_enable !== want.write_enable) begin
                $display("%0t: write_enable expected %0b actual %0b",
                         $time, want.write_enable, got.write_enable);
                errors++;
            end
            if (got.target_address !== want.target_address) begin
                $display("%0t: target_address expected %0h actual %0h",
                         $time, want.target_address, got.target_address);
                errors++;
            end
            if (got.blended_pixel !== want.blended_pixel) begin
                $display("%0t: blended_pixel expected %08h actual %08h",
                         $time, want.blended_pixel, got.blended_pixel);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [8:0] src_col, [17:9] src_row, [49:18] src_pixel, [81:50] dst_pixel, rest zero
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    // [0] write_enable, [26:1] target_address, [58:27] blended_pixel, rest zero
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]       cfg_data = '0;

    // Random idling on both sides is switched off for the closing phases.
    bit                     idle_on = 1'b1;
    int unsigned            cycle_count = 0;
    blit_scoreboard         sb = new();

    clipped_source_over_blit_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // Watchdog: a correct run ends far below this count.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Monitor. All handshakes are sampled at the rising edge, before the values driven at
    // that edge take effect. The result is checked before the new input is noted, which
    // keeps the order right even for a block that could answer in the same cycle.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_pixel(s_axis_tdata);
        end
    end

    // Receiver: runs of ready broken by random stall bursts while idling is on.
    initial
    begin
        @(posedge clk);
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            if (idle_on && $urandom_range(0, 1) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
        end
    end

    // Offers one pixel item and returns at the edge where it is accepted. Valid stays high
    // so that a following call can present its item in the very next cycle; a gap lowers
    // it in the acceptance step instead, so valid never gets two updates in one step.
    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                              input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] dst);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - IN_FIELDS_W){1'b0}}, dst, src, row, col};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Waits until every outstanding result has come back and the pipeline has emptied.
    // The first edge lets the monitor note an item accepted at the edge just passed.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_writes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all four registers back to back; only called while the block is idle.
    task automatic write_regs(input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height,
                              input logic [DIM_W-1:0] off_x, input logic [DIM_W-1:0] off_y);
        logic [CFG_INDEX_W-1:0] idx[4];
        logic [DIM_W-1:0]       val[4];
        idx = '{REG_DEST_WIDTH, REG_DEST_HEIGHT, REG_OFFSET_X, REG_OFFSET_Y};
        val = '{width, height, off_x, off_y};
        wait_drained();
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Pixels with opaque and clear alpha, properly premultiplied colors, and arbitrary
    // words whose color exceeds alpha so that the saturation path is reached.
    function automatic logic [PIX_W-1:0] random_argb();
        logic [CH_W-1:0] a;
        a = CH_W'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0:       return {8'h00, 24'($urandom)};
            1:       return {8'hff, 24'($urandom)};
            2, 3:    return {a, 8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
                             8'($urandom_range(0, a))};
            default: return $urandom;
        endcase
    endfunction

    // Picks a width or height register value: tiny, typical, the limit, above the limit
    // (which saturates), zero now and then, and anything else the field can hold.
    function automatic logic [DIM_W-1:0] random_dim();
        case ($urandom_range(0, 9))
            0:       return DIM_W'($urandom_range(0, 2));
            1:       return DIM_W'($urandom_range(1, 16));
            2:       return DIM_W'(MAX_DEST_DIM);
            3:       return DIM_W'($urandom_range(MAX_DEST_DIM + 1, 16383));
            4:       return DIM_W'($urandom_range(0, 16383));
            default: return DIM_W'($urandom_range(8, 700));
        endcase
    endfunction

    // Picks an offset: mostly one that puts the clip edge inside the overlay, sometimes
    // the signed extremes or any value at all.
    function automatic logic [DIM_W-1:0] random_offset(input int extent);
        int off;
        case ($urandom_range(0, 7))
            0:       return DIM_W'($urandom_range(0, 16383));
            1:       return DIM_W'(8191);
            2:       return DIM_W'(-8192);
            default:
            begin
                off = int'($urandom_range(0, extent + 520)) - 520;
                return DIM_W'((off > 8191) ? 8191 : off);
            end
        endcase
    endfunction

    // A coordinate that is uniform most of the time and otherwise sits right at a clip edge.
    function automatic logic [COORD_W-1:0] random_coord(input int extent, input int off);
        int edge_pos;
        if ($urandom_range(0, 3) != 0)
            return COORD_W'($urandom_range(0, 511));
        edge_pos = ($urandom_range(0, 1) ? extent : 0) - off + int'($urandom_range(0, 2)) - 1;
        if (edge_pos < 0 || edge_pos > 511)
            return ($urandom_range(0, 1) ? 9'd511 : 9'd0);
        return COORD_W'(edge_pos);
    endfunction

    // One random setting of the four registers followed by a stream of pixels.
    task automatic random_phase(input int unsigned count);
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] off_x;
        logic [DIM_W-1:0] off_y;
        int               eff_w;
        int               eff_h;
        width  = random_dim();
        height = random_dim();
        eff_w  = (width > MAX_DEST_DIM) ? MAX_DEST_DIM : int'(width);
        eff_h  = (height > MAX_DEST_DIM) ? MAX_DEST_DIM : int'(height);
        off_x  = random_offset(eff_w);
        off_y  = random_offset(eff_h);
        write_regs(width, height, off_x, off_y);
        repeat (count)
        begin
            send_pixel(random_coord(eff_w, $signed(off_x)), random_coord(eff_h, $signed(off_y)),
                       random_argb(), random_argb());
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults after reset: clear, opaque, half and saturating blends, and
        // the overlay corners, all inside the 1920 by 1080 destination.
        send_pixel(9'd0, 9'd0, 32'h0000_0000, 32'h0000_0000);
        send_pixel(9'd0, 9'd0, 32'hffff_ffff, 32'h1234_5678);
        send_pixel(9'd511, 9'd511, 32'h0000_0000, 32'hffff_ffff);
        send_pixel(9'd1, 9'd2, 32'h80ff_ffff, 32'hffff_ffff);
        send_pixel(9'd511, 9'd0, 32'h7f7f_7f7f, 32'hffff_ffff);
        send_pixel(9'd0, 9'd511, 32'h0101_0101, 32'hfefe_fefe);

        // A one-pixel destination: only the overlay origin lands inside.
        write_regs(14'd1, 14'd1, 14'd0, 14'd0);
        send_pixel(9'd0, 9'd0, 32'hc080_4020, 32'h5566_7788);
        send_pixel(9'd1, 9'd0, 32'hc080_4020, 32'h5566_7788);
        send_pixel(9'd0, 9'd1, 32'hc080_4020, 32'h5566_7788);

        // Zero width clips everything.
        write_regs(14'd0, 14'd1080, 14'd0, 14'd0);
        send_pixel(9'd0, 9'd0, 32'hffff_ffff, 32'hffff_ffff);

        // Oversized registers saturate to the maximum; the largest offsets put the origin
        // on the very last destination pixel and its neighbors just outside.
        write_regs(14'h3fff, 14'h3fff, 14'd8191, 14'd8191);
        send_pixel(9'd0, 9'd0, 32'h4020_1008, 32'hffff_ffff);
        send_pixel(9'd1, 9'd0, 32'h4020_1008, 32'hffff_ffff);
        send_pixel(9'd0, 9'd1, 32'h4020_1008, 32'hffff_ffff);

        // The most negative offset pushes the whole overlay off the top-left.
        write_regs(14'd8192, 14'd8192, 14'h2000, 14'h2000);
        send_pixel(9'd511, 9'd511, 32'hffff_ffff, 32'h0000_0000);

        // An offset of -511 leaves only the far overlay corner, at address zero.
        write_regs(14'd8192, 14'd8192, DIM_W'(-511), DIM_W'(-511));
        send_pixel(9'd511, 9'd511, 32'h8040_2010, 32'h8080_8080);
        send_pixel(9'd510, 9'd511, 32'h8040_2010, 32'h8080_8080);
        send_pixel(9'd511, 9'd510, 32'h8040_2010, 32'h8080_8080);

        // A narrow strip shifted left by one: column zero falls off the left edge.
        write_regs(14'd600, 14'd1, DIM_W'(-1), 14'd0);
        send_pixel(9'd0, 9'd0, 32'hffff_ffff, 32'h0000_0000);
        send_pixel(9'd1, 9'd0, 32'h3f3f_3f3f, 32'hc0c0_c0c0);
        send_pixel(9'd300, 9'd0, 32'h00ff_ffff, 32'h0000_0001);

        // Random settings and pixels; the closing phases run without any idling.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p >= RANDOM_PHASES - 2)
                idle_on = 1'b0;
            random_phase(PHASE_ITEMS);
        end

        wait_drained();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
